// File: hw/rtl/string_allow_block_list_matcher_assert.svh
// Assertion helpers used by the matcher RTL.
`ifndef STRING_ALLOW_BLOCK_LIST_MATCHER_ASSERT_SVH
`define STRING_ALLOW_BLOCK_LIST_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SABLM_CHK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SABLM_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sablm_pkg.sv
package sablm_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] LS_STORED = 2'd0;
  localparam logic [1:0] LS_FULL   = 2'd1;
  localparam logic [1:0] LS_LONG   = 2'd2;

  localparam logic [1:0] VD_DEFAULT = 2'd0;
  localparam logic [1:0] VD_BLOCK   = 2'd1;
  localparam logic [1:0] VD_ALLOW   = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic LIST_BLOCK = 1'b0;
  localparam logic LIST_ALLOW = 1'b1;

  localparam logic SEC_TEXT = 1'b0;

  localparam logic REG_BLOCK_EN = 1'b0;
  localparam logic REG_ALLOW_EN = 1'b1;

  typedef struct packed {
    logic chr_we;
    logic chr_re;
    logic len_we;
    logic len_re;
  } store_ctrl_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LEN_RD  = 6'b000010,
    S_LEN_CHK = 6'b000100,
    S_CHR_RD  = 6'b001000,
    S_CHR_CHK = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

endpackage

// File: hw/rtl/sablm_store.sv
module sablm_store import sablm_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int ENTRY_LEN   = 128
) (
  input  logic                                   clk,
  input  store_ctrl_t                            ctrl,
  input  logic [2+((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)+$clog2(ENTRY_LEN)-1:0]
                                                 chr_addr,
  input  logic [7:0]                             chr_wdata,
  output logic [7:0]                             chr_rdata,
  input  logic [2+((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0]
                                                 len_addr,
  input  logic [$clog2(ENTRY_LEN)-1:0]           len_wdata,
  output logic [$clog2(ENTRY_LEN)-1:0]           len_rdata
);

  localparam int EW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW        = $clog2(ENTRY_LEN);
  localparam int LAW       = 2 + EW;
  localparam int CAW       = LAW + CW;
  localparam int CHR_DEPTH = 1 << CAW;
  localparam int LEN_DEPTH = 1 << LAW;

  logic [7:0]    chr_mem [0:CHR_DEPTH-1];
  logic [CW-1:0] len_mem [0:LEN_DEPTH-1];

  always_ff @(posedge clk) begin
    if (ctrl.chr_we) begin
      chr_mem[chr_addr] <= chr_wdata;
    end
    if (ctrl.chr_re) begin
      chr_rdata <= chr_mem[chr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.len_we) begin
      len_mem[len_addr] <= len_wdata;
    end
    if (ctrl.len_re) begin
      len_rdata <= len_mem[len_addr];
    end
  end

endmodule

// File: hw/rtl/string_allow_block_list_matcher.sv
// Channel   Ports                                       Handshake
// config    cfg_we cfg_index cfg_data                   write when cfg_we
// input     in_cmd in_list_select in_section_select     start & !busy
//           in_char_byte
// result    out_result_kind out_load_status out_verdict out_strobe, one cycle
//
// Clear and load or query bytes leave busy low; a load terminator strobes next cycle.
// A query terminator holds busy while both lists are scanned, each entry's length read
// first and its characters compared only if the lengths are equal; a hit stops that
// list's scan, and an empty or overlong string skips both scans. A text query keeps
// its hits with no strobe; others strobe a verdict as busy falls. Reset (synchronous,
// rst_n low) empties lists and query with no clearing pass; receiver cannot stall.
`include "string_allow_block_list_matcher_assert.svh"

module string_allow_block_list_matcher import sablm_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int ENTRY_LEN   = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  logic       in_list_select,
  input  logic       in_section_select,
  input  logic [7:0] in_char_byte,
  output logic       busy,
  output logic       out_strobe,
  output logic       out_result_kind,
  output logic [1:0] out_load_status,
  output logic [1:0] out_verdict
);

  localparam int EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRY_LEN);
  localparam int PW   = $clog2(ENTRY_LEN + 1);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int LAW  = 2 + EW;
  localparam int CAW  = LAW + CW;
  localparam int QDEPTH = 1 << CW;

  localparam logic [PW-1:0]   LAST_POS = PW'(ENTRY_LEN - 1);
  localparam logic [PW-1:0]   LONG_POS = PW'(ENTRY_LEN);
  localparam logic [CNTW-1:0] CNT_MAX  = CNTW'(MAX_ENTRIES);

  state_t          st_r, st_nxt;
  logic [CNTW-1:0] cnt_r [4];
  logic [CNTW-1:0] cnt_nxt [4];
  logic [PW-1:0]   pos_r [4];
  logic [PW-1:0]   pos_nxt [4];
  logic [PW-1:0]   qlen_r, qlen_nxt;
  logic [1:0]      text_hits_r, text_hits_nxt;
  logic [1:0]      hit_r, hit_nxt;
  logic            blk_en_r, alw_en_r;
  logic            scan_list_r, scan_list_nxt;
  logic            scan_sec_r, scan_sec_nxt;
  logic [CNTW-1:0] ent_r, ent_nxt;
  logic [CW-1:0]   chr_r, chr_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [1:0]      out_verdict_r, out_verdict_nxt;

  store_ctrl_t     ctrl;
  logic [CAW-1:0]  chr_addr;
  logic [LAW-1:0]  len_addr;
  logic [7:0]      chr_rdata;
  logic [CW-1:0]   len_rdata;

  logic [7:0]      qmem [0:QDEPTH-1];
  logic [7:0]      qchr_r;
  logic            q_we;

  logic [1:0]      ld_sec;
  logic [1:0]      cur_sec;
  logic [CNTW-1:0] cur_cnt;
  logic            found;
  logic            pass_done;
  logic            blk_hit;
  logic            alw_hit;

  assign ld_sec  = {in_list_select, in_section_select};
  assign cur_sec = {scan_list_r, scan_sec_r};
  assign cur_cnt = cnt_r[cur_sec];
  assign busy    = (st_r != S_IDLE);
  assign blk_hit = text_hits_r[0] | hit_r[0];
  assign alw_hit = text_hits_r[1] | hit_r[1];

  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    pos_nxt         = pos_r;
    qlen_nxt        = qlen_r;
    text_hits_nxt   = text_hits_r;
    hit_nxt         = hit_r;
    scan_list_nxt   = scan_list_r;
    scan_sec_nxt    = scan_sec_r;
    ent_nxt         = ent_r;
    chr_nxt         = chr_r;
    out_strobe_nxt  = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_verdict_nxt = out_verdict_r;
    ctrl            = '0;
    q_we            = 1'b0;
    chr_addr        = {cur_sec, ent_r[EW-1:0], chr_r};
    len_addr        = {cur_sec, ent_r[EW-1:0]};
    found           = 1'b0;
    pass_done       = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              cnt_nxt[{in_list_select, 1'b0}] = '0;
              cnt_nxt[{in_list_select, 1'b1}] = '0;
              pos_nxt[{in_list_select, 1'b0}] = '0;
              pos_nxt[{in_list_select, 1'b1}] = '0;
            end
            CMD_LOAD: begin
              chr_addr = {ld_sec, cnt_r[ld_sec][EW-1:0], pos_r[ld_sec][CW-1:0]};
              len_addr = {ld_sec, cnt_r[ld_sec][EW-1:0]};
              if (in_char_byte != 8'd0) begin
                if (pos_r[ld_sec] < LAST_POS) begin
                  ctrl.chr_we     = (cnt_r[ld_sec] < CNT_MAX);
                  pos_nxt[ld_sec] = pos_r[ld_sec] + PW'(1);
                end else begin
                  pos_nxt[ld_sec] = LONG_POS;
                end
              end else begin
                pos_nxt[ld_sec] = '0;
                out_strobe_nxt  = 1'b1;
                out_kind_nxt    = KIND_LOAD;
                out_verdict_nxt = VD_DEFAULT;
                if (cnt_r[ld_sec] >= CNT_MAX) begin
                  out_status_nxt = LS_FULL;
                end else if (pos_r[ld_sec] >= LONG_POS) begin
                  out_status_nxt = LS_LONG;
                end else begin
                  ctrl.len_we     = 1'b1;
                  cnt_nxt[ld_sec] = cnt_r[ld_sec] + CNTW'(1);
                  out_status_nxt  = LS_STORED;
                end
              end
            end
            CMD_QUERY: begin
              if (in_char_byte != 8'd0) begin
                if (qlen_r < LAST_POS) begin
                  q_we     = 1'b1;
                  qlen_nxt = qlen_r + PW'(1);
                end else begin
                  qlen_nxt = LONG_POS;
                end
              end else begin
                scan_sec_nxt  = in_section_select;
                scan_list_nxt = LIST_BLOCK;
                hit_nxt       = '0;
                ent_nxt       = '0;
                if (qlen_r != '0 && qlen_r < LONG_POS) begin
                  st_nxt = S_LEN_RD;
                end else begin
                  st_nxt = S_FIN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN_RD: begin
        if (ent_r < cur_cnt) begin
          ctrl.len_re = 1'b1;
          st_nxt      = S_LEN_CHK;
        end else begin
          pass_done = 1'b1;
        end
      end
      S_LEN_CHK: begin
        if (PW'(len_rdata) == qlen_r) begin
          chr_nxt = '0;
          st_nxt  = S_CHR_RD;
        end else begin
          ent_nxt = ent_r + CNTW'(1);
          st_nxt  = S_LEN_RD;
        end
      end
      S_CHR_RD: begin
        ctrl.chr_re = 1'b1;
        st_nxt      = S_CHR_CHK;
      end
      S_CHR_CHK: begin
        if (chr_rdata != qchr_r) begin
          ent_nxt = ent_r + CNTW'(1);
          st_nxt  = S_LEN_RD;
        end else if ((PW'(chr_r) + PW'(1)) == qlen_r) begin
          found     = 1'b1;
          pass_done = 1'b1;
        end else begin
          chr_nxt = chr_r + CW'(1);
          st_nxt  = S_CHR_RD;
        end
      end
      S_FIN: begin
        if (scan_sec_r == SEC_TEXT) begin
          text_hits_nxt = hit_r;
        end else begin
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_VERDICT;
          out_status_nxt = LS_STORED;
          priority if (blk_en_r && blk_hit) begin
            out_verdict_nxt = VD_BLOCK;
          end else if (alw_en_r && alw_hit) begin
            out_verdict_nxt = VD_ALLOW;
          end else begin
            out_verdict_nxt = VD_DEFAULT;
          end
          text_hits_nxt = '0;
        end
        qlen_nxt = '0;
        st_nxt   = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (pass_done) begin
      hit_nxt[scan_list_r] = found;
      if (scan_list_r == LIST_BLOCK) begin
        scan_list_nxt = LIST_ALLOW;
        ent_nxt       = '0;
        st_nxt        = S_LEN_RD;
      end else begin
        st_nxt = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '{default: '0};
      pos_r        <= '{default: '0};
      qlen_r       <= '0;
      text_hits_r  <= '0;
      blk_en_r     <= 1'b0;
      alw_en_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      pos_r        <= pos_nxt;
      qlen_r       <= qlen_nxt;
      text_hits_r  <= text_hits_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we && cfg_index == REG_BLOCK_EN) begin
        blk_en_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_ALLOW_EN) begin
        alw_en_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r         <= hit_nxt;
    scan_list_r   <= scan_list_nxt;
    scan_sec_r    <= scan_sec_nxt;
    ent_r         <= ent_nxt;
    chr_r         <= chr_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  // query string buffer
  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[qlen_r[CW-1:0]] <= in_char_byte;
    end
    qchr_r <= qmem[chr_r];
  end

  sablm_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ENTRY_LEN   (ENTRY_LEN)
  ) u_store (
    .clk       (clk),
    .ctrl      (ctrl),
    .chr_addr  (chr_addr),
    .chr_wdata (in_char_byte),
    .chr_rdata (chr_rdata),
    .len_addr  (len_addr),
    .len_wdata (pos_r[ld_sec][CW-1:0]),
    .len_rdata (len_rdata)
  );

  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_load_status = out_status_r;
  assign out_verdict     = out_verdict_r;

  `SABLM_CHK(a_verdict_status_zero, out_strobe && out_result_kind == KIND_VERDICT, out_load_status == LS_STORED, "verdict transaction carries a load status")
  `SABLM_CHK(a_status_verdict_zero, out_strobe && out_result_kind == KIND_LOAD, out_verdict == VD_DEFAULT, "load transaction carries a verdict")
  `SABLM_CHK(a_entry_in_range, st_r == S_LEN_RD, ent_r <= cur_cnt, "scan index ran past section count")
  `SABLM_CHK(a_char_in_range, st_r == S_CHR_RD, (PW'(chr_r) < qlen_r), "char index ran past query length")
  `SABLM_CHK_NEXT(a_load_term_result, start && !busy && in_cmd == CMD_LOAD && in_char_byte == 8'd0, out_strobe && out_result_kind == KIND_LOAD, "load terminator gave no status")

endmodule
